### rtl/pagr_pkg.sv
// ----------------------------------------------------------------------------
// pagr_pkg: shared types and constants
// Command and result words, store entry layout, pseudo-float format and
// register codes of the accumulation buffer with gamma resolve.
// ----------------------------------------------------------------------------
package pagr_pkg;

  localparam int unsigned MaxWidthDef   = 256;
  localparam int unsigned MaxHeightDef  = 256;
  localparam int unsigned SampleBitsDef = 16;

  localparam int unsigned SumW    = 32;
  localparam int unsigned CountW  = 16;
  localparam int unsigned ExpW    = 12;
  localparam int unsigned GammaW  = 6;
  localparam int unsigned SizeW   = 9;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 9;

  localparam logic [GammaW-1:0] GammaRst = 6'd10;
  localparam logic [GammaW-1:0] GammaMax = 6'd50;
  localparam logic [GammaW-1:0] GammaOne = 6'd1;
  localparam logic [GammaW-1:0] PowXN    = 6'd10;
  localparam logic [SizeW-1:0]  SizeRst  = 9'd256;
  localparam logic [15:0]       FrameRst = 16'd1;

  typedef enum logic [1:0] {
    OP_ACCUM   = 2'd0,
    OP_RESOLVE = 2'd1,
    OP_CLEAR   = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAMMA  = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] pixel_index;
    logic [15:0] sample_red;
    logic [15:0] sample_green;
    logic [15:0] sample_blue;
  } cmd_t;

  typedef struct packed {
    logic [23:0] packed_pixel;
    logic        frame_end;
    logic [15:0] frame_number;
  } res_t;

  typedef struct packed {
    logic [SumW-1:0]   sum_red;
    logic [SumW-1:0]   sum_green;
    logic [SumW-1:0]   sum_blue;
    logic [CountW-1:0] count;
  } entry_t;

  // value = m * 2^e, m normalized to [2^31, 2^32)
  typedef struct packed {
    logic [31:0]            m;
    logic signed [ExpW-1:0] e;
  } pf_t;

endpackage

### rtl/pagr_store.sv
// ----------------------------------------------------------------------------
// pagr_store: pixel accumulation memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pagr_store import pagr_pkg::*; #(
  parameter int unsigned Depth = MaxWidthDef * MaxHeightDef,
  parameter int unsigned AddrW = 16
) (
  input  logic             clk_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output entry_t           rdata_o,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  entry_t           wdata_i
);

  entry_t mem [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/pagr_pow.sv
// ----------------------------------------------------------------------------
// pagr_pow: pseudo-float power unit
// Normalize the base one bit a cycle, then multiply left to right, one
// truncating 32x32 product a cycle.
// ----------------------------------------------------------------------------
module pagr_pow import pagr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [31:0]            raw_i,
  input  logic signed [ExpW-1:0] exp_i,
  input  logic [GammaW-1:0]      n_i,
  output logic                   done_o,
  output pf_t                    res_o
);

  typedef enum logic [1:0] {
    PW_IDLE,
    PW_NORM,
    PW_MUL
  } pw_state_e;

  pw_state_e         state_q;
  logic              done_q;
  logic [GammaW-1:0] cnt_q;
  pf_t               b_q;
  pf_t               r_q;
  logic [63:0]       prod;
  pf_t               r_next;

  assign prod = 64'(r_q.m) * 64'(b_q.m);

  always_comb begin
    if (prod[63]) begin
      r_next.m = prod[63:32];
      r_next.e = r_q.e + b_q.e + ExpW'(32);
    end else begin
      r_next.m = prod[62:31];
      r_next.e = r_q.e + b_q.e + ExpW'(31);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PW_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      b_q     <= '0;
      r_q     <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        PW_IDLE: begin
          if (start_i) begin
            b_q.m   <= raw_i;
            b_q.e   <= exp_i;
            cnt_q   <= n_i;
            state_q <= PW_NORM;
          end
        end
        PW_NORM: begin
          if (b_q.m[31]) begin
            r_q <= b_q;
            if (cnt_q <= GammaOne) begin
              done_q  <= 1'b1;
              state_q <= PW_IDLE;
            end else begin
              cnt_q   <= cnt_q - GammaOne;
              state_q <= PW_MUL;
            end
          end else begin
            b_q.m <= {b_q.m[30:0], 1'b0};
            b_q.e <= b_q.e - ExpW'(1);
          end
        end
        PW_MUL: begin
          r_q   <= r_next;
          cnt_q <= cnt_q - GammaOne;
          if (cnt_q == GammaOne) begin
            done_q  <= 1'b1;
            state_q <= PW_IDLE;
          end
        end
        default: state_q <= PW_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = r_q;

endmodule

### rtl/pagr_chan.sv
// ----------------------------------------------------------------------------
// pagr_chan: one color channel of the resolve
// Divide the sum by the count one quotient bit a cycle, raise the average
// to the tenth power, then binary search the output byte against k/255.99
// raised to gamma.
// ----------------------------------------------------------------------------
module pagr_chan import pagr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SumW-1:0]   sum_i,
  input  logic [CountW-1:0] count_i,
  input  logic [GammaW-1:0] gamma_i,
  output logic              done_o,
  output logic [7:0]        byte_o
);

  localparam logic [63:0] TStep = 64'd429496729600;  // 100 * 2^32
  localparam logic [63:0] TDiv  = 64'd25599;
  localparam logic [31:0] TQ [8] = '{
    32'((TStep << 0) / TDiv), 32'((TStep << 1) / TDiv),
    32'((TStep << 2) / TDiv), 32'((TStep << 3) / TDiv),
    32'((TStep << 4) / TDiv), 32'((TStep << 5) / TDiv),
    32'((TStep << 6) / TDiv), 32'((TStep << 7) / TDiv)
  };
  localparam logic [14:0] TR [8] = '{
    15'((TStep << 0) % TDiv), 15'((TStep << 1) % TDiv),
    15'((TStep << 2) % TDiv), 15'((TStep << 3) % TDiv),
    15'((TStep << 4) % TDiv), 15'((TStep << 5) % TDiv),
    15'((TStep << 6) % TDiv), 15'((TStep << 7) % TDiv)
  };
  localparam logic signed [ExpW-1:0] XExp = ExpW'(-16);
  localparam logic signed [ExpW-1:0] TExp = ExpW'(-32);

  typedef enum logic [2:0] {
    CH_IDLE,
    CH_DIV,
    CH_PX_GO,
    CH_PX_WAIT,
    CH_T_GO,
    CH_T_WAIT
  } ch_state_e;

  ch_state_e         state_q;
  logic              done_q;
  logic [CountW-1:0] count_q;
  logic [GammaW-1:0] g_q;
  logic [15:0]       rem_q;
  logic [15:0]       nb_q;
  logic [15:0]       quo_q;
  logic [3:0]        step_q;
  logic [16:0]       x_q;
  pf_t               px_q;
  logic [7:0]        k_q;
  logic [31:0]       tq_q;
  logic [14:0]       tr_q;
  logic [2:0]        j_q;

  logic [16:0]       rs;
  logic              rs_ge;
  logic [15:0]       rem_d;
  logic [15:0]       quo_d;
  logic [15:0]       tr_sum;
  logic              t_carry;
  logic [14:0]       cand_r;
  logic [31:0]       cand_t;
  logic              pw_start;
  logic [31:0]       pw_raw;
  logic signed [ExpW-1:0] pw_exp;
  logic [GammaW-1:0] pw_n;
  logic              pw_done;
  pf_t               pw_res;
  logic              t_le;

  // restoring division step
  assign rs    = {rem_q, nb_q[15]};
  assign rs_ge = rs >= {1'b0, count_q};
  assign rem_d = rs_ge ? 16'(rs - {1'b0, count_q}) : rs[15:0];
  assign quo_d = {quo_q[14:0], rs_ge};

  // t for the trial byte k | 2^j, kept as quotient and remainder
  assign tr_sum  = {1'b0, tr_q} + {1'b0, TR[j_q]};
  assign t_carry = tr_sum >= 16'(TDiv);
  assign cand_r  = t_carry ? 15'(tr_sum - 16'(TDiv)) : tr_sum[14:0];
  assign cand_t  = tq_q + TQ[j_q] + 32'(t_carry);

  assign pw_start = (state_q == CH_PX_GO) || (state_q == CH_T_GO);
  assign pw_raw   = (state_q == CH_PX_GO) ? 32'(x_q) : cand_t;
  assign pw_exp   = (state_q == CH_PX_GO) ? XExp : TExp;
  assign pw_n     = (state_q == CH_PX_GO) ? PowXN : g_q;

  assign t_le = (pw_res.e != px_q.e) ? (pw_res.e < px_q.e) : (pw_res.m <= px_q.m);

  pagr_pow u_pow (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (pw_start),
    .raw_i   (pw_raw),
    .exp_i   (pw_exp),
    .n_i     (pw_n),
    .done_o  (pw_done),
    .res_o   (pw_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CH_IDLE;
      done_q  <= 1'b0;
      count_q <= '0;
      g_q     <= '0;
      rem_q   <= '0;
      nb_q    <= '0;
      quo_q   <= '0;
      step_q  <= '0;
      x_q     <= '0;
      px_q    <= '0;
      k_q     <= '0;
      tq_q    <= '0;
      tr_q    <= '0;
      j_q     <= '0;
    end else begin
      unique case (state_q)
        CH_IDLE: begin
          if (start_i) begin
            done_q  <= 1'b0;
            count_q <= count_i;
            g_q     <= gamma_i;
            k_q     <= '0;
            if (sum_i >= {8'd0, count_i, 8'd0}) begin
              x_q     <= 17'h10000;  // average clamps at one
              state_q <= CH_PX_GO;
            end else begin
              rem_q   <= sum_i[23:8];
              nb_q    <= {sum_i[7:0], 8'd0};
              step_q  <= 4'd15;
              state_q <= CH_DIV;
            end
          end
        end
        CH_DIV: begin
          rem_q  <= rem_d;
          nb_q   <= {nb_q[14:0], 1'b0};
          quo_q  <= quo_d;
          step_q <= step_q - 4'd1;
          if (step_q == 4'd0) begin
            x_q <= {1'b0, quo_d};
            if (quo_d == 16'd0) begin
              done_q  <= 1'b1;
              state_q <= CH_IDLE;
            end else begin
              state_q <= CH_PX_GO;
            end
          end
        end
        CH_PX_GO: state_q <= CH_PX_WAIT;
        CH_PX_WAIT: begin
          if (pw_done) begin
            px_q    <= pw_res;
            tq_q    <= '0;
            tr_q    <= '0;
            j_q     <= 3'd7;
            state_q <= CH_T_GO;
          end
        end
        CH_T_GO: state_q <= CH_T_WAIT;
        CH_T_WAIT: begin
          if (pw_done) begin
            if (t_le) begin
              k_q  <= k_q | (8'd1 << j_q);
              tq_q <= cand_t;
              tr_q <= cand_r;
            end
            if (j_q == 3'd0) begin
              done_q  <= 1'b1;
              state_q <= CH_IDLE;
            end else begin
              j_q     <= j_q - 3'd1;
              state_q <= CH_T_GO;
            end
          end
        end
        default: state_q <= CH_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign byte_o = k_q;

endmodule

### rtl/progressive_accumulate_gamma_resolve.sv
// ----------------------------------------------------------------------------
// progressive_accumulate_gamma_resolve: accumulation buffer with gamma resolve
// Per-pixel RGB sample accumulation in raster order and gamma-corrected
// readout of single pixels.
// ----------------------------------------------------------------------------
// Usage: drive a command word on cmd_i and raise start; it is taken at the
// edge where start is high and busy is low. Each command gives exactly one
// result word on res_o, marked by res_valid_o for one cycle; the receiver
// cannot stall, so sample it on that cycle.
//   accumulate: memory read, then saturating add and write-back;
//     the result carries frame_end and frame_number on scan wrap.
//   resolve: zero result for an empty pixel or out-of-range index; otherwise a
//     bit-serial divide and the shared-per-channel 32x32 multiplier, which
//     raises the average to the tenth power and each search trial to the
//     gamma power. The three channels run side by side.
//   clear: one memory entry per cycle.
//   unused code 3: result on the next cycle, no busy time.
// Reset starts the same clearing pass (busy high, no result). Write registers
// through cfg_we_i only while no command is in flight.
// ----------------------------------------------------------------------------
module progressive_accumulate_gamma_resolve import pagr_pkg::*; #(
  parameter int unsigned MAX_WIDTH   = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT  = MaxHeightDef,
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  cmd_t               cmd_i,
  output logic               res_valid_o,
  output res_t               res_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned ColW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RowW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned WdW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HtW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned ProdW = RowW + WdW;
  localparam logic [15:0] SampleMask =
    (SAMPLE_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << SAMPLE_BITS) - 32'd1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_RES_RD,
    ST_RES_CHK,
    ST_RES_RUN,
    ST_CLR
  } state_e;

  state_e            state_q;
  cmd_t              cmd_q;
  logic [AddrW-1:0]  acc_addr_q;
  logic [AddrW-1:0]  clr_addr_q;
  logic              clr_report_q;
  logic [ColW-1:0]   col_q;
  logic [RowW-1:0]   row_q;
  logic [15:0]       frame_q;
  logic [GammaW-1:0] gamma_q;
  logic [SizeW-1:0]  width_q;
  logic [SizeW-1:0]  height_q;
  logic              res_valid_q;
  res_t              res_q;

  logic [WdW-1:0]    w_eff;
  logic [HtW-1:0]    h_eff;
  logic [GammaW-1:0] g_eff;
  logic [ProdW-1:0]  scan_prod;
  logic [AddrW-1:0]  scan_addr;
  logic [ColW:0]     col_inc;
  logic [RowW:0]     row_inc;
  logic              idx_ok;

  logic              mem_re;
  logic [AddrW-1:0]  mem_raddr;
  entry_t            mem_rdata;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  entry_t            mem_wdata;
  entry_t            acc_entry;

  logic              ch_start;
  logic [2:0]        ch_done;
  logic [7:0]        byte_r;
  logic [7:0]        byte_g;
  logic [7:0]        byte_b;

  // clamp configured sizes and gamma to their legal ranges
  always_comb begin
    if (width_q == '0) begin
      w_eff = WdW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WdW'(MAX_WIDTH);
    end else begin
      w_eff = WdW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = HtW'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = HtW'(MAX_HEIGHT);
    end else begin
      h_eff = HtW'(height_q);
    end
    if (gamma_q == '0) begin
      g_eff = GammaOne;
    end else if (gamma_q > GammaMax) begin
      g_eff = GammaMax;
    end else begin
      g_eff = gamma_q;
    end
  end

  // scan position to store address; always inside the store
  assign scan_prod = ProdW'(row_q) * ProdW'(w_eff);
  assign scan_addr = AddrW'(scan_prod + ProdW'(col_q));
  assign col_inc   = {1'b0, col_q} + (ColW+1)'(1);
  assign row_inc   = {1'b0, row_q} + (RowW+1)'(1);
  assign idx_ok    = 32'(cmd_q.pixel_index) < 32'(Depth);

  function automatic logic [SumW-1:0] sat_add(logic [SumW-1:0] a, logic [15:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + (SumW+1)'(b);
    return s[SumW] ? '1 : s[SumW-1:0];
  endfunction

  always_comb begin
    acc_entry.sum_red   = sat_add(mem_rdata.sum_red, cmd_q.sample_red & SampleMask);
    acc_entry.sum_green = sat_add(mem_rdata.sum_green, cmd_q.sample_green & SampleMask);
    acc_entry.sum_blue  = sat_add(mem_rdata.sum_blue, cmd_q.sample_blue & SampleMask);
    acc_entry.count     = (mem_rdata.count == '1) ? mem_rdata.count
                                                  : mem_rdata.count + CountW'(1);
  end

  // memory port steering
  assign mem_re    = (state_q == ST_ACC_RD) || (state_q == ST_RES_RD);
  assign mem_raddr = (state_q == ST_ACC_RD) ? acc_addr_q : AddrW'(cmd_q.pixel_index);
  assign mem_we    = (state_q == ST_ACC_WR) || (state_q == ST_CLR);
  assign mem_waddr = (state_q == ST_CLR) ? clr_addr_q : acc_addr_q;
  assign mem_wdata = (state_q == ST_CLR) ? entry_t'('0) : acc_entry;

  pagr_store #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata)
  );

  assign ch_start = (state_q == ST_RES_CHK) && idx_ok && (mem_rdata.count != '0);

  pagr_chan u_chan_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ch_start),
    .sum_i   (mem_rdata.sum_red),
    .count_i (mem_rdata.count),
    .gamma_i (g_eff),
    .done_o  (ch_done[0]),
    .byte_o  (byte_r)
  );

  pagr_chan u_chan_g (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ch_start),
    .sum_i   (mem_rdata.sum_green),
    .count_i (mem_rdata.count),
    .gamma_i (g_eff),
    .done_o  (ch_done[1]),
    .byte_o  (byte_g)
  );

  pagr_chan u_chan_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ch_start),
    .sum_i   (mem_rdata.sum_blue),
    .count_i (mem_rdata.count),
    .gamma_i (g_eff),
    .done_o  (ch_done[2]),
    .byte_o  (byte_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLR;
      cmd_q        <= '0;
      acc_addr_q   <= '0;
      clr_addr_q   <= '0;
      clr_report_q <= 1'b0;
      col_q        <= '0;
      row_q        <= '0;
      frame_q      <= FrameRst;
      gamma_q      <= GammaRst;
      width_q      <= SizeRst;
      height_q     <= SizeRst;
      res_valid_q  <= 1'b0;
      res_q        <= '0;
    end else begin
      res_valid_q <= 1'b0;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_GAMMA:  gamma_q  <= cfg_data_i[GammaW-1:0];
          CFG_WIDTH:  width_q  <= cfg_data_i[SizeW-1:0];
          CFG_HEIGHT: height_q <= cfg_data_i[SizeW-1:0];
          default: ;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            cmd_q <= cmd_i;
            unique case (cmd_i.operation)
              OP_ACCUM: begin
                acc_addr_q <= scan_addr;
                state_q    <= ST_ACC_RD;
              end
              OP_RESOLVE: state_q <= ST_RES_RD;
              OP_CLEAR: begin
                col_q        <= '0;
                row_q        <= '0;
                frame_q      <= FrameRst;
                clr_addr_q   <= '0;
                clr_report_q <= 1'b1;
                state_q      <= ST_CLR;
              end
              default: begin
                res_valid_q <= 1'b1;
                res_q       <= '0;
              end
            endcase
          end
        end
        ST_ACC_RD: state_q <= ST_ACC_WR;
        ST_ACC_WR: begin
          res_valid_q <= 1'b1;
          if (32'(col_inc) >= 32'(w_eff)) begin
            col_q <= '0;
            if (32'(row_inc) >= 32'(h_eff)) begin
              row_q <= '0;
              res_q <= '{packed_pixel: 24'd0, frame_end: 1'b1, frame_number: frame_q};
              if (frame_q != 16'hFFFF) begin
                frame_q <= frame_q + 16'd1;
              end
            end else begin
              row_q <= row_inc[RowW-1:0];
              res_q <= '0;
            end
          end else begin
            col_q <= col_inc[ColW-1:0];
            res_q <= '0;
          end
          state_q <= ST_IDLE;
        end
        ST_RES_RD: state_q <= ST_RES_CHK;
        ST_RES_CHK: begin
          if (ch_start) begin
            state_q <= ST_RES_RUN;
          end else begin
            // empty pixel or index past the store
            res_valid_q <= 1'b1;
            res_q       <= '0;
            state_q     <= ST_IDLE;
          end
        end
        ST_RES_RUN: begin
          if (&ch_done) begin
            res_valid_q <= 1'b1;
            res_q       <= '{packed_pixel: {byte_b, byte_g, byte_r}, frame_end: 1'b0,
                             frame_number: 16'd0};
            state_q     <= ST_IDLE;
          end
        end
        ST_CLR: begin
          clr_addr_q <= clr_addr_q + AddrW'(1);
          if (clr_addr_q == AddrW'(Depth - 1)) begin
            if (clr_report_q) begin
              res_valid_q <= 1'b1;
              res_q       <= '0;
            end
            clr_report_q <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef NO_ASSERTIONS
  // a taken command leaves the block busy or answers on the next cycle
  a_start_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || res_valid_o)
    else $error("accepted command neither busy nor answered");

  // a frame end always reports a completed frame
  a_frame_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.frame_end |-> res_o.frame_number != 16'd0)
    else $error("frame end with frame number zero");

  // only resolve produces color, and resolve never ends a frame
  a_color_no_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.packed_pixel != 24'd0) |-> !res_o.frame_end)
    else $error("color and frame end in one result");

  // the store is not written while the channels work on a read entry
  a_no_write_resolve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RES_RUN) || (state_q == ST_RES_CHK) |-> !mem_we)
    else $error("store written during resolve");

  // a write-back always follows its own read
  a_rmw_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC_WR) |-> $past(state_q == ST_ACC_RD))
    else $error("write-back without read");
`endif

endmodule
